/* design/asv_pkg.sv */
package asv_pkg;

  localparam int unsigned GYRO_W    = 32;
  localparam int unsigned GYRO_MAXW = 31;
  localparam int unsigned SUN_W     = 16;
  localparam int unsigned SUN_SQW   = 32;
  localparam int unsigned MAG_W     = 20;
  localparam int unsigned MAG_SQW   = 40;
  localparam int unsigned SRC_W     = 3;
  localparam int unsigned VLD_W     = 3;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned FLAG_W    = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 40;
  localparam int unsigned IN_UW     = 7;
  localparam int unsigned IN_DW     = 208;
  localparam int unsigned OUT_UW    = 5;
  localparam int unsigned OUT_DW    = 272;

  // Bit positions inside valid_in.
  localparam int unsigned VLD_GYRO = 0;
  localparam int unsigned VLD_SUN  = 1;
  localparam int unsigned VLD_MAG  = 2;

  // Bit positions inside status_flags.
  localparam int unsigned ST_SRC  = 0;
  localparam int unsigned ST_GYRO = 1;
  localparam int unsigned ST_SUN  = 2;
  localparam int unsigned ST_MAG  = 3;
  localparam int unsigned ST_PKT  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_MASK    = 3'd0,
    REG_GYRO_MAX    = 3'd1,
    REG_SUN_SQ_MIN  = 3'd2,
    REG_SUN_SQ_MAX  = 3'd3,
    REG_MAG_SQ_MIN  = 3'd4,
    REG_MAG_SQ_MAX  = 3'd5
  } cfg_reg_t;

  localparam logic [MASK_W-1:0]    RST_SRC_MASK   = 8'd14;
  localparam logic [GYRO_MAXW-1:0] RST_GYRO_MAX   = 31'd655360;
  localparam logic [SUN_SQW-1:0]   RST_SUN_SQ_MIN = 32'd217432719;
  localparam logic [SUN_SQW-1:0]   RST_SUN_SQ_MAX = 32'd324806901;
  localparam logic [MAG_SQW-1:0]   RST_MAG_SQ_MIN = 40'd1000000;
  localparam logic [MAG_SQW-1:0]   RST_MAG_SQ_MAX = 40'd40000000000;

  typedef struct packed {
    logic [MASK_W-1:0]    src_mask;
    logic [GYRO_MAXW-1:0] gyro_max;
    logic [SUN_SQW-1:0]   sun_sq_min;
    logic [SUN_SQW-1:0]   sun_sq_max;
    logic [MAG_SQW-1:0]   mag_sq_min;
    logic [MAG_SQW-1:0]   mag_sq_max;
  } cfg_t;

  typedef struct packed {
    logic                    packet_present;
    logic [SRC_W-1:0]        source_code;
    logic [VLD_W-1:0]        valid_in;
    logic signed [GYRO_W-1:0] gyro_x;
    logic signed [GYRO_W-1:0] gyro_y;
    logic signed [GYRO_W-1:0] gyro_z;
    logic signed [SUN_W-1:0]  sun_x;
    logic signed [SUN_W-1:0]  sun_y;
    logic signed [SUN_W-1:0]  sun_z;
    logic signed [MAG_W-1:0]  mag_x;
    logic signed [MAG_W-1:0]  mag_y;
    logic signed [MAG_W-1:0]  mag_z;
  } pkt_t;

  typedef struct packed {
    logic [FLAG_W-1:0]        status_flags;
    logic signed [GYRO_W-1:0] gyro_x;
    logic signed [GYRO_W-1:0] gyro_y;
    logic signed [GYRO_W-1:0] gyro_z;
    logic signed [SUN_W-1:0]  sun_x;
    logic signed [SUN_W-1:0]  sun_y;
    logic signed [SUN_W-1:0]  sun_z;
    logic signed [MAG_W-1:0]  mag_x;
    logic signed [MAG_W-1:0]  mag_y;
    logic signed [MAG_W-1:0]  mag_z;
  } res_t;

endpackage

/* design/asv_check.sv */
module asv_check (
  input  asv_pkg::pkt_t pkt,
  input  asv_pkg::cfg_t cfg,
  output asv_pkg::res_t res
);

  logic [asv_pkg::GYRO_W-1:0]  gx_abs, gy_abs, gz_abs;
  logic [asv_pkg::GYRO_W-1:0]  gyro_lim;
  logic [asv_pkg::SUN_SQW-1:0] sx_sq, sy_sq, sz_sq, sun_sq;
  logic [asv_pkg::MAG_SQW-1:0] mx_sq, my_sq, mz_sq, mag_sq;
  logic src_ok, gyro_ok, sun_ok, mag_ok, pkt_ok;

  // The most negative value negates to 2^31, which still fits the unsigned word.
  assign gx_abs = pkt.gyro_x[asv_pkg::GYRO_W-1] ? (~pkt.gyro_x + 1'b1) : pkt.gyro_x;
  assign gy_abs = pkt.gyro_y[asv_pkg::GYRO_W-1] ? (~pkt.gyro_y + 1'b1) : pkt.gyro_y;
  assign gz_abs = pkt.gyro_z[asv_pkg::GYRO_W-1] ? (~pkt.gyro_z + 1'b1) : pkt.gyro_z;
  assign gyro_lim = {1'b0, cfg.gyro_max};

  // Three full-scale squares sum below 2^32 (sun) and 2^40 (mag), so no carry is lost.
  assign sx_sq  = 32'(pkt.sun_x) * 32'(pkt.sun_x);
  assign sy_sq  = 32'(pkt.sun_y) * 32'(pkt.sun_y);
  assign sz_sq  = 32'(pkt.sun_z) * 32'(pkt.sun_z);
  assign sun_sq = sx_sq + sy_sq + sz_sq;

  assign mx_sq  = 40'(pkt.mag_x) * 40'(pkt.mag_x);
  assign my_sq  = 40'(pkt.mag_y) * 40'(pkt.mag_y);
  assign mz_sq  = 40'(pkt.mag_z) * 40'(pkt.mag_z);
  assign mag_sq = mx_sq + my_sq + mz_sq;

  always_comb begin
    src_ok  = pkt.packet_present && cfg.src_mask[pkt.source_code];
    gyro_ok = pkt.packet_present && pkt.valid_in[asv_pkg::VLD_GYRO] &&
              (gx_abs <= gyro_lim) && (gy_abs <= gyro_lim) && (gz_abs <= gyro_lim);
    sun_ok  = pkt.packet_present && pkt.valid_in[asv_pkg::VLD_SUN] &&
              (sun_sq >= cfg.sun_sq_min) && (sun_sq <= cfg.sun_sq_max);
    mag_ok  = pkt.packet_present && pkt.valid_in[asv_pkg::VLD_MAG] &&
              (mag_sq >= cfg.mag_sq_min) && (mag_sq <= cfg.mag_sq_max);
    pkt_ok  = src_ok && gyro_ok && sun_ok && mag_ok;

    res.status_flags                   = '0;
    res.status_flags[asv_pkg::ST_SRC]  = src_ok;
    res.status_flags[asv_pkg::ST_GYRO] = gyro_ok;
    res.status_flags[asv_pkg::ST_SUN]  = sun_ok;
    res.status_flags[asv_pkg::ST_MAG]  = mag_ok;
    res.status_flags[asv_pkg::ST_PKT]  = pkt_ok;

    res.gyro_x = gyro_ok ? pkt.gyro_x : '0;
    res.gyro_y = gyro_ok ? pkt.gyro_y : '0;
    res.gyro_z = gyro_ok ? pkt.gyro_z : '0;
    res.sun_x  = sun_ok  ? pkt.sun_x  : '0;
    res.sun_y  = sun_ok  ? pkt.sun_y  : '0;
    res.sun_z  = sun_ok  ? pkt.sun_z  : '0;
    res.mag_x  = mag_ok  ? pkt.mag_x  : '0;
    res.mag_y  = mag_ok  ? pkt.mag_y  : '0;
    res.mag_z  = mag_ok  ? pkt.mag_z  : '0;
  end

endmodule

/* design/attitude_sensor_packet_validator.sv */
// Channel  Direction  Transfer carries
// in_      slave      one sensor packet (flags in tuser, vectors in tdata)
// out_     master     one checked result (status in tuser, vectors and counters in tdata)
// cfg_     write      one limit register per write, no read-back
//
// Each packet is held first in the input register; then the checks and squares
// land in the result register. One packet is accepted per cycle while the output
// is not stalled; the input register refills while a result waits.
// Synchronous active-low reset clears valids and the running counters (not the
// output copies) and loads the limit registers with their power-up values.
// A stalled output holds its result and backs up the input register only.
module attitude_sensor_packet_validator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // tuser, low bit up: packet_present, source_code[2:0], valid_in[2:0]
  input  logic [asv_pkg::IN_UW-1:0]    in_tuser,
  // tdata, low bit up: gyro_x, gyro_y, gyro_z, sun_x, sun_y, sun_z,
  // mag_x, mag_y, mag_z, zero fill
  input  logic [asv_pkg::IN_DW-1:0]    in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // tuser, low bit up: status_flags[4:0]
  output logic [asv_pkg::OUT_UW-1:0]   out_tuser,
  // tdata, low bit up: gyro_out_x, gyro_out_y, gyro_out_z, sun_out_x, sun_out_y,
  // sun_out_z, mag_out_x, mag_out_y, mag_out_z, total_checked, bad_total, zero fill
  output logic [asv_pkg::OUT_DW-1:0]   out_tdata,
  input  logic                         cfg_wr_en,
  input  logic [asv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asv_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int unsigned VEC_W = 3 * asv_pkg::GYRO_W + 3 * asv_pkg::SUN_W +
                                  3 * asv_pkg::MAG_W;

  asv_pkg::cfg_t cfg_r, cfg_nxt;
  asv_pkg::pkt_t pkt_r, pkt_nxt;
  asv_pkg::res_t res_c, res_r, res_nxt;
  logic          pkt_vld_r, pkt_vld_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic [asv_pkg::CNT_W-1:0] checked_r, checked_nxt;
  logic [asv_pkg::CNT_W-1:0] bad_r, bad_nxt;
  logic [asv_pkg::CNT_W-1:0] total_out_r, total_out_nxt;
  logic [asv_pkg::CNT_W-1:0] bad_out_r, bad_out_nxt;
  logic          advance;
  logic          in_xfer;

  asv_check u_check (
    .pkt (pkt_r),
    .cfg (cfg_r),
    .res (res_c)
  );

  assign advance   = pkt_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !pkt_vld_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        asv_pkg::REG_SRC_MASK:   cfg_nxt.src_mask   = cfg_wdata[asv_pkg::MASK_W-1:0];
        asv_pkg::REG_GYRO_MAX:   cfg_nxt.gyro_max   = cfg_wdata[asv_pkg::GYRO_MAXW-1:0];
        asv_pkg::REG_SUN_SQ_MIN: cfg_nxt.sun_sq_min = cfg_wdata[asv_pkg::SUN_SQW-1:0];
        asv_pkg::REG_SUN_SQ_MAX: cfg_nxt.sun_sq_max = cfg_wdata[asv_pkg::SUN_SQW-1:0];
        asv_pkg::REG_MAG_SQ_MIN: cfg_nxt.mag_sq_min = cfg_wdata[asv_pkg::MAG_SQW-1:0];
        asv_pkg::REG_MAG_SQ_MAX: cfg_nxt.mag_sq_max = cfg_wdata[asv_pkg::MAG_SQW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pkt_nxt     = pkt_r;
    pkt_vld_nxt = pkt_vld_r;
    if (in_xfer) begin
      pkt_nxt.packet_present = in_tuser[0];
      pkt_nxt.source_code    = in_tuser[3:1];
      pkt_nxt.valid_in       = in_tuser[6:4];
      {pkt_nxt.mag_z, pkt_nxt.mag_y, pkt_nxt.mag_x,
       pkt_nxt.sun_z, pkt_nxt.sun_y, pkt_nxt.sun_x,
       pkt_nxt.gyro_z, pkt_nxt.gyro_y, pkt_nxt.gyro_x} = in_tdata[VEC_W-1:0];
      pkt_vld_nxt = 1'b1;
    end else if (advance) begin
      pkt_vld_nxt = 1'b0;
    end
  end

  // Counters step when a packet moves into the result register.
  always_comb begin
    res_nxt       = res_r;
    out_vld_nxt   = out_vld_r;
    checked_nxt   = checked_r;
    bad_nxt       = bad_r;
    total_out_nxt = total_out_r;
    bad_out_nxt   = bad_out_r;
    if (advance) begin
      checked_nxt = checked_r + 1'b1;
      bad_nxt     = res_c.status_flags[asv_pkg::ST_PKT] ? bad_r : bad_r + 1'b1;
      res_nxt       = res_c;
      total_out_nxt = checked_nxt;
      bad_out_nxt   = bad_nxt;
      out_vld_nxt   = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r       <= pkt_nxt;
    res_r       <= res_nxt;
    total_out_r <= total_out_nxt;
    bad_out_r   <= bad_out_nxt;
    if (!rst_n) begin
      cfg_r.src_mask   <= asv_pkg::RST_SRC_MASK;
      cfg_r.gyro_max   <= asv_pkg::RST_GYRO_MAX;
      cfg_r.sun_sq_min <= asv_pkg::RST_SUN_SQ_MIN;
      cfg_r.sun_sq_max <= asv_pkg::RST_SUN_SQ_MAX;
      cfg_r.mag_sq_min <= asv_pkg::RST_MAG_SQ_MIN;
      cfg_r.mag_sq_max <= asv_pkg::RST_MAG_SQ_MAX;
      pkt_vld_r        <= 1'b0;
      out_vld_r        <= 1'b0;
      checked_r        <= '0;
      bad_r            <= '0;
    end else begin
      cfg_r     <= cfg_nxt;
      pkt_vld_r <= pkt_vld_nxt;
      out_vld_r <= out_vld_nxt;
      checked_r <= checked_nxt;
      bad_r     <= bad_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.status_flags;
  assign out_tdata  = {{(asv_pkg::OUT_DW - VEC_W - 2 * asv_pkg::CNT_W){1'b0}},
                       bad_out_r, total_out_r,
                       res_r.mag_z, res_r.mag_y, res_r.mag_x,
                       res_r.sun_z, res_r.sun_y, res_r.sun_x,
                       res_r.gyro_z, res_r.gyro_y, res_r.gyro_x};

endmodule
